// ===== rtl/shp_pkg.sv =====
`default_nettype none

package shp_pkg;

    localparam int unsigned AGE_W = 31;
    localparam int unsigned POS_W = 5;
    localparam int unsigned ACC_W = AGE_W + 4;

    localparam logic [POS_W-1:0] AGE_WORD_LEN = 5'd7;
    localparam logic [POS_W-1:0] SUB_WORD_LEN = 5'd17;
    localparam logic [POS_W-1:0] POS_MAX      = 5'd31;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;

    typedef enum logic [5:0] {
        P_START = 6'b000001,
        P_LABEL = 6'b000010,
        P_EQ    = 6'b000100,
        P_AGE   = 6'b001000,
        P_SEP   = 6'b010000,
        P_SUB   = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic               in_token;
        logic [POS_W-1:0]   pos;
        logic               mismatch;
        logic               failed;
        logic [AGE_W-1:0]   age;
        logic               negative;
        logic               digit_seen;
        logic               overflow;
    } t_state;

    typedef struct packed {
        logic               header_valid;
        logic [AGE_W-1:0]   max_age;
        logic               incl_subdomains;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:      P_START,
        in_token:   1'b0,
        pos:        '0,
        mismatch:   1'b0,
        failed:     1'b0,
        age:        '0,
        negative:   1'b0,
        digit_seen: 1'b0,
        overflow:   1'b0
    };

    // "max-age"
    function automatic logic [7:0] age_word_char(input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = 8'h6D;
            5'd1:    ch = 8'h61;
            5'd2:    ch = 8'h78;
            5'd3:    ch = 8'h2D;
            5'd4:    ch = 8'h61;
            5'd5:    ch = 8'h67;
            5'd6:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "includesubdomains"
    function automatic logic [7:0] sub_word_char(input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = 8'h69;
            5'd1:    ch = 8'h6E;
            5'd2:    ch = 8'h63;
            5'd3:    ch = 8'h6C;
            5'd4:    ch = 8'h75;
            5'd5:    ch = 8'h64;
            5'd6:    ch = 8'h65;
            5'd7:    ch = 8'h73;
            5'd8:    ch = 8'h75;
            5'd9:    ch = 8'h62;
            5'd10:   ch = 8'h64;
            5'd11:   ch = 8'h6F;
            5'd12:   ch = 8'h6D;
            5'd13:   ch = 8'h61;
            5'd14:   ch = 8'h69;
            5'd15:   ch = 8'h6E;
            5'd16:   ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] ch);
        logic [7:0] res;
        res = ch;
        if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
            res = ch | CH_CASE;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/shp_step.sv =====
`default_nettype none

module shp_step (
    input  var shp_pkg::t_state  i_state,
    input  wire                  i_has_byte,
    input  wire  [7:0]           i_header_byte,
    input  wire                  i_last,
    output var shp_pkg::t_state  o_state,
    output var shp_pkg::t_result o_result
);

    // closes the current token and checks it against what the phase expects
    function automatic shp_pkg::t_state token_end(input shp_pkg::t_state st);
        shp_pkg::t_state s;
        s = st;
        if (s.in_token) begin
            s.in_token = 1'b0;
            if (!s.failed) begin
                case (s.phase)
                    shp_pkg::P_START: begin
                        if (!s.mismatch && s.pos == shp_pkg::AGE_WORD_LEN) begin
                            s.phase = shp_pkg::P_LABEL;
                        end else begin
                            s.failed = 1'b1;
                        end
                    end
                    shp_pkg::P_SEP: begin
                        if (!s.mismatch && s.pos == shp_pkg::SUB_WORD_LEN) begin
                            s.phase = shp_pkg::P_SUB;
                        end else begin
                            s.failed = 1'b1;
                        end
                    end
                    shp_pkg::P_EQ: begin
                        if (s.mismatch || !s.digit_seen || s.overflow ||
                            (s.negative && s.age != '0)) begin
                            s.failed = 1'b1;
                        end else begin
                            s.phase = shp_pkg::P_AGE;
                        end
                    end
                    default: ;
                endcase
            end
        end
        return s;
    endfunction

    shp_pkg::t_state             s;
    logic [shp_pkg::ACC_W-1:0]   acc;
    logic [shp_pkg::ACC_W-1:0]   age_ext;
    logic [3:0]                  digit;
    logic                        blocked;
    logic                        ok;

    always_comb begin
        s       = i_state;
        blocked = 1'b0;
        digit   = 4'(i_header_byte - shp_pkg::CH_ZERO);
        age_ext = '0;
        acc     = '0;

        if (i_has_byte) begin
            if (i_header_byte == shp_pkg::CH_SPACE || i_header_byte == shp_pkg::CH_EQUAL) begin
                s = token_end(s);
                if (!s.failed) begin
                    if (i_header_byte == shp_pkg::CH_SPACE) begin
                        if (s.phase == shp_pkg::P_AGE) begin
                            s.phase = shp_pkg::P_SEP;
                        end
                    end else if (s.phase == shp_pkg::P_LABEL) begin
                        s.phase = shp_pkg::P_EQ;
                    end else begin
                        s.failed = 1'b1;
                    end
                end
            end else if (!s.failed) begin
                if (!s.in_token) begin
                    s.in_token   = 1'b1;
                    s.pos        = '0;
                    s.mismatch   = 1'b0;
                    s.age        = '0;
                    s.negative   = 1'b0;
                    s.digit_seen = 1'b0;
                    s.overflow   = 1'b0;
                    if (s.phase inside {shp_pkg::P_LABEL, shp_pkg::P_AGE, shp_pkg::P_SUB}) begin
                        s.failed = 1'b1;
                        blocked  = 1'b1;
                    end
                end
                if (!blocked) begin
                    case (s.phase)
                        shp_pkg::P_START: begin
                            if (s.pos >= shp_pkg::AGE_WORD_LEN ||
                                shp_pkg::fold_case(i_header_byte) !=
                                shp_pkg::age_word_char(s.pos)) begin
                                s.mismatch = 1'b1;
                            end
                        end
                        shp_pkg::P_SEP: begin
                            if (s.pos >= shp_pkg::SUB_WORD_LEN ||
                                shp_pkg::fold_case(i_header_byte) !=
                                shp_pkg::sub_word_char(s.pos)) begin
                                s.mismatch = 1'b1;
                            end
                        end
                        shp_pkg::P_EQ: begin
                            if (s.pos == '0 && (i_header_byte == shp_pkg::CH_PLUS ||
                                                i_header_byte == shp_pkg::CH_MINUS)) begin
                                s.negative = (i_header_byte == shp_pkg::CH_MINUS);
                            end else if (i_header_byte inside
                                         {[shp_pkg::CH_ZERO:shp_pkg::CH_NINE]}) begin
                                s.digit_seen = 1'b1;
                                if (!s.overflow) begin
                                    // age * 10 + digit as two shifts and adds
                                    age_ext = shp_pkg::ACC_W'(s.age);
                                    acc = (age_ext << 3) + (age_ext << 1) +
                                          shp_pkg::ACC_W'(digit);
                                    if (acc[shp_pkg::ACC_W-1:shp_pkg::AGE_W] != '0) begin
                                        s.overflow = 1'b1;
                                    end else begin
                                        s.age = acc[shp_pkg::AGE_W-1:0];
                                    end
                                end
                            end else begin
                                s.mismatch = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (s.pos < shp_pkg::POS_MAX) begin
                        s.pos = s.pos + 1'b1;
                    end
                end
            end
        end

        o_result = '0;
        if (i_last) begin
            s  = token_end(s);
            ok = !s.failed &&
                 (s.phase inside {shp_pkg::P_AGE, shp_pkg::P_SEP, shp_pkg::P_SUB});
            o_result.header_valid    = ok;
            o_result.max_age         = ok ? s.age : '0;
            o_result.incl_subdomains = ok && (s.phase == shp_pkg::P_SUB);
            o_state = shp_pkg::STATE_RESET;
        end else begin
            ok      = 1'b0;
            o_state = s;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sts_header_parser_core.sv =====
// Streaming parser for a strict-transport-security header value, one byte per
// transaction. A new byte is taken in every cycle: it lands in an input
// register, from which the parse state is advanced by that byte in one step
// (keyword compare, or age * 10 + digit), and the transaction marked last loads
// the result register. The result register holds under o_valid/i_stall while
// input keeps flowing; only a last byte stalls the input when a result still
// waits. After reset the parser is ready at once and returns to its start
// state after every last byte.
`default_nettype none

module sts_header_parser_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_has_byte,
    input  wire  [7:0]                   i_header_byte,
    input  wire                          i_last,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_header_valid,
    output logic [shp_pkg::AGE_W-1:0]    o_max_age,
    output logic                         o_incl_subdomains
);

    logic                r_in_vld;
    logic                r_in_has;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    shp_pkg::t_state     r_state;
    logic                r_out_vld;
    shp_pkg::t_result    r_out;

    shp_pkg::t_state     n_state;
    shp_pkg::t_result    step_result;
    logic                out_free;
    logic                proc;
    logic                in_take;

    shp_step u_step (
        .i_state        (r_state),
        .i_has_byte     (r_in_has),
        .i_header_byte  (r_in_byte),
        .i_last         (r_in_last),
        .o_state        (n_state),
        .o_result       (step_result)
    );

    assign out_free = !r_out_vld || !i_stall;
    // a byte without a result never waits on the output side
    assign proc     = r_in_vld && (!r_in_last || out_free);
    assign o_stall  = r_in_vld && !proc;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_state   <= shp_pkg::STATE_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (proc && r_in_last) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_has  <= i_has_byte;
            r_in_byte <= i_header_byte;
            r_in_last <= i_last;
        end
        if (proc && r_in_last) begin
            r_out <= step_result;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_header_valid    = r_out.header_valid;
    assign o_max_age         = r_out.max_age;
    assign o_incl_subdomains = r_out.incl_subdomains;

`ifndef NO_ASSERTIONS
    a_invalid_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_header_valid |-> o_max_age == '0 && !o_incl_subdomains)
        else $error("invalid header result carries nonzero fields");

    a_sub_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_incl_subdomains |-> o_header_valid)
        else $error("subdomain flag set on an invalid header");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> r_state.phase == shp_pkg::P_START && !r_state.in_token &&
                              !r_state.failed)
        else $error("parse state not restarted after last byte");

    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !proc |=> r_in_vld && $stable(r_in_byte) && $stable(r_in_last))
        else $error("waiting input byte lost or overwritten");

    a_result_loaded_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |-> out_free)
        else $error("result register overwritten while still pending");
`endif

endmodule

`default_nettype wire
